>>> hdl/hmcp_pkg.sv
// Package with the word types, codes and character constants of the hex monitor command parser.
package hmcp_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] character;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] first_address;
    logic [31:0] last_address;
    logic [7:0]  write_data;
  } out_word_t;

  typedef enum logic [2:0] {
    MODE_READ  = 3'd0,
    MODE_WRITE = 3'd1,
    MODE_GO    = 3'd2,
    MODE_HELP  = 3'd3,
    MODE_ADDRS = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    CLS_HEX,
    CLS_SPACE,
    CLS_COLON,
    CLS_DOT,
    CLS_PLUS,
    CLS_QUEST,
    CLS_AT,
    CLS_GO,
    CLS_OTHER
  } char_cls_t;

  typedef struct packed {
    char_cls_t  cls;
    logic [3:0] digit;
  } char_info_t;

  localparam logic       OP_CHAR = 1'b0;
  localparam logic       OP_EOL  = 1'b1;

  localparam logic [2:0] KIND_DUMP    = 3'd0;
  localparam logic [2:0] KIND_WRITE   = 3'd1;
  localparam logic [2:0] KIND_GO      = 3'd2;
  localparam logic [2:0] KIND_RESTART = 3'd3;
  localparam logic [2:0] KIND_HELP    = 3'd4;
  localparam logic [2:0] KIND_ADDRS   = 3'd5;
  localparam logic [2:0] KIND_SHOW    = 3'd6;

  localparam logic [31:0] RANGE_SPAN = 32'h0000_000F;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] HEX_TEN  = 8'd10;

endpackage

>>> hdl/hex_monitor_command_parser.sv
// Top level of the hex monitor command parser: input register, parser engine, result register.
//
// The input channel carries one word per command character or end of line (op set).
// A word is taken when in_valid is high and in_stall is low. The result channel
// carries at most one word per input word: a dump range, byte write, go, restart,
// help, addresses or show-address request, taken when out_valid is high and
// out_stall is low. The restart address is written through the cfg channel, which
// is always ready and should only be used while the parser is idle.
// Each input word is registered in the input register, processed combinationally by the
// parser logic, and its result is registered in the result register.
// The block takes one word per cycle for as long as results are drained.
// When the receiver stalls, the pending result is held; words that produce no
// result still move through, and the input side stalls only once a word with a
// result finds the result register occupied.
// Reset clears both addresses, returns to read mode at the start of an empty line,
// sets the restart address to zero and empties both registers.
module hex_monitor_command_parser import hmcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic        in_valid_r;
  in_word_t    in_word_r;
  logic        out_valid_r;
  out_word_t   out_word_r;
  logic [31:0] restart_r;
  logic        res_valid;
  out_word_t   res_word;
  logic        fire;

  assign cfg_ready = 1'b1;
  assign fire      = in_valid_r && (!res_valid || !out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !fire;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  hmcp_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .word            (in_word_r),
    .restart_address (restart_r),
    .res_valid       (res_valid),
    .res_word        (res_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      restart_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_word_r <= res_word;
    end
  end

endmodule

>>> hdl/hmcp_char_class.sv
// Character classifier: hex digit value or terminator class of one command character.
module hmcp_char_class import hmcp_pkg::*; (
  input  logic [7:0] ch,
  output char_info_t info
);

  logic [7:0] num_val;
  logic [7:0] let_val;

  assign num_val = ch - CH_0;
  assign let_val = ch - CH_A + HEX_TEN;

  always_comb begin
    info.digit = 4'd0;
    case (ch) inside
      [CH_0:CH_9]: begin
        info.cls   = CLS_HEX;
        info.digit = num_val[3:0];
      end
      [CH_A:CH_F]: begin
        info.cls   = CLS_HEX;
        info.digit = let_val[3:0];
      end
      CH_SPACE: info.cls = CLS_SPACE;
      CH_COLON: info.cls = CLS_COLON;
      CH_DOT:   info.cls = CLS_DOT;
      CH_PLUS:  info.cls = CLS_PLUS;
      CH_QUEST: info.cls = CLS_QUEST;
      CH_AT:    info.cls = CLS_AT;
      CH_G:     info.cls = CLS_GO;
      default:  info.cls = CLS_OTHER;
    endcase
  end

endmodule

>>> hdl/hmcp_engine.sv
// Parser state registers and the single-pass update that yields at most one result word.
module hmcp_engine import hmcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  in_word_t    word,
  input  logic [31:0] restart_address,
  output logic        res_valid,
  output out_word_t   res_word
);

  logic [31:0] start_r, start_nxt;
  logic [31:0] end_r, end_nxt;
  mode_t       mode_r, mode_nxt;
  logic        tgt_r, tgt_nxt;
  logic        seg_r, seg_nxt;
  logic        empty_r, empty_nxt;
  char_info_t  info;

  hmcp_char_class u_class (
    .ch   (word.character),
    .info (info)
  );

  always_comb begin : update
    logic first;
    logic do_close;
    start_nxt = start_r;
    end_nxt   = end_r;
    mode_nxt  = mode_r;
    tgt_nxt   = tgt_r;
    seg_nxt   = seg_r;
    empty_nxt = empty_r;
    first     = 1'b0;
    do_close  = 1'b0;
    res_valid = 1'b0;
    res_word  = '0;

    if (word.op == OP_EOL) begin
      do_close = seg_r;
      if (!seg_r && empty_r) begin
        res_valid              = 1'b1;
        res_word.kind          = KIND_SHOW;
        res_word.first_address = start_r;
      end
    end else begin
      empty_nxt = 1'b0;
      if (!seg_r) begin
        seg_nxt = 1'b1;
        first   = 1'b1;
        end_nxt = start_r;
        tgt_nxt = (mode_r == MODE_WRITE);
      end
      case (info.cls)
        CLS_HEX: begin
          if (tgt_nxt) begin
            end_nxt = {(first ? 28'd0 : end_nxt[27:0]), info.digit};
          end else begin
            start_nxt = {(first ? 28'd0 : start_nxt[27:0]), info.digit};
          end
        end
        CLS_SPACE: do_close = 1'b1;
        CLS_COLON: begin
          mode_nxt = MODE_WRITE;
          tgt_nxt  = 1'b1;
          end_nxt  = '0;
        end
        CLS_DOT: begin
          tgt_nxt = 1'b1;
          end_nxt = '0;
        end
        CLS_PLUS: begin
          tgt_nxt  = 1'b1;
          end_nxt  = start_nxt + RANGE_SPAN;
          do_close = 1'b1;
        end
        CLS_QUEST: begin
          mode_nxt = MODE_HELP;
          do_close = 1'b1;
        end
        CLS_AT: begin
          mode_nxt = MODE_ADDRS;
          do_close = 1'b1;
        end
        CLS_GO: begin
          mode_nxt = MODE_GO;
          do_close = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (do_close) begin
      if (!tgt_nxt) begin
        end_nxt = start_nxt;
      end
      seg_nxt   = 1'b0;
      res_valid = 1'b1;
      case (mode_nxt)
        MODE_WRITE: begin
          res_word.kind          = KIND_WRITE;
          res_word.first_address = start_nxt;
          res_word.write_data    = end_nxt[7:0];
          start_nxt              = start_nxt + 32'd1;
        end
        MODE_GO: begin
          res_word.kind = (start_nxt == restart_address) ? KIND_RESTART : KIND_GO;
          res_word.first_address = start_nxt;
        end
        MODE_HELP:  res_word.kind = KIND_HELP;
        MODE_ADDRS: res_word.kind = KIND_ADDRS;
        default: begin
          res_word.kind          = KIND_DUMP;
          res_word.first_address = start_nxt;
          res_word.last_address  = end_nxt;
        end
      endcase
    end

    if (word.op == OP_EOL) begin
      mode_nxt  = MODE_READ;
      tgt_nxt   = 1'b0;
      seg_nxt   = 1'b0;
      empty_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
      mode_r  <= MODE_READ;
      tgt_r   <= 1'b0;
      seg_r   <= 1'b0;
      empty_r <= 1'b1;
    end else if (fire) begin
      start_r <= start_nxt;
      end_r   <= end_nxt;
      mode_r  <= mode_nxt;
      tgt_r   <= tgt_nxt;
      seg_r   <= seg_nxt;
      empty_r <= empty_nxt;
    end
  end

endmodule
